### rtl/core/rmts_pkg.sv
// Shared types and constants for the rate monotonic task scheduler.
package rmts_pkg;

  localparam int unsigned TASKS = 16;
  localparam int unsigned IDX_W = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int unsigned CNT_W = IDX_W + 1;

  localparam int unsigned DIV_W = 36;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W + 1);

  localparam logic [19:0] MILLIONTHS = 20'd1000000;
  localparam logic [19:0] THRESH_RESET = 20'd693000;

  typedef enum logic [1:0] {
    FUNC_REG   = 2'd0,
    FUNC_DEREG = 2'd1,
    FUNC_YIELD = 2'd2,
    FUNC_TICK  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_REJECT      = 2'd1,
    ST_NOT_FOUND   = 2'd2,
    ST_ZERO_PERIOD = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MODE_READY    = 2'd0,
    MODE_RUNNING  = 2'd1,
    MODE_SLEEPING = 2'd2
  } mode_e;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_DIVS, S_DIVW, S_ADMIT, S_FIND, S_ACT, S_YFIN, S_DISP, S_DFIN, S_OUT
  } state_e;

  typedef struct packed {
    logic [21:0] pid;
    logic [15:0] period;
    logic [19:0] usage;
    logic [31:0] deadline;
    logic [31:0] wake;
  } slot_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [15:0]      divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [15:0]      rem;
  } div_rsp_t;

endpackage

### rtl/core/rmts_div.sv
// Restoring divider, one quotient bit per cycle.
module rmts_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rmts_pkg::div_req_t req_i,
  output rmts_pkg::div_rsp_t rsp_o
);
  import rmts_pkg::*;

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0]     quot_q;
  logic [15:0]          rem_q;
  logic [16:0]          trial, diff;
  logic                 ge;

  // Shift in one dividend bit and try the subtract
  always_comb begin
    trial = {rem_q, quot_q[DIV_W-1]};
    diff  = trial - {1'b0, req_i.divisor};
    ge    = (trial >= {1'b0, req_i.divisor});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Hold quotient and partial remainder
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quot_q <= req_i.dividend;
      rem_q  <= '0;
    end else if (busy_q) begin
      quot_q <= {quot_q[DIV_W-2:0], ge};
      rem_q  <= ge ? diff[15:0] : trial[15:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q;

endmodule

### rtl/core/rate_monotonic_task_scheduler.sv
// Rate monotonic scheduler top level: task table, sequencer and dispatch scan.
//
//  channel | handshake               | payload
//  in      | in_valid_i / in_stall_o | func_i pid_i period_ms_i runtime_ms_i now_i
//  out     | out_valid_o / out_stall_i | status_o run_valid_o run_pid_o total_usage_o
//  cfg     | cfg_we_i                | cfg_data_i (admit threshold)
//
// One word at a time; a new word is taken only once the last result is accepted.
// Register runs multiply, 36-step serial divide, admit and dispatch scan; a yield
// past its deadline runs lookup scan, divide and dispatch scan; deregister and an
// on-time yield run lookup and dispatch scans; tick and a zero-period register run
// the dispatch scan only. The shared divider and the one-read-port table set the pace.
// Reset clears the used flags, the usage sum and the running task; no clearing pass.
// A stalled result holds out_valid_o and the payload; no new word is taken meanwhile.
module rate_monotonic_task_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [21:0] pid_i,
  input  logic [15:0] period_ms_i,
  input  logic [15:0] runtime_ms_i,
  input  logic [31:0] now_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic        run_valid_o,
  output logic [21:0] run_pid_o,
  output logic [19:0] total_usage_o,
  input  logic        cfg_we_i,
  input  logic [19:0] cfg_data_i
);
  import rmts_pkg::*;

  state_e state_q, state_d;

  // Latched request
  func_e       func_q;
  logic [21:0] pid_q;
  logic [15:0] period_q, runtime_q;
  logic [31:0] now_q;

  logic [19:0]      thr_q, sum_q;
  status_e          status_q;
  logic [DIV_W-1:0] prod_q;

  // Table: flags in flops, payload in a memory with one read and one write port
  logic       used_q [TASKS];
  mode_e      mode_q [TASKS];
  slot_t      mem [TASKS];
  slot_t      rd_q;
  logic       mem_we;
  logic [IDX_W-1:0] mem_wa, rd_addr;
  slot_t      mem_wd;

  // Scan pipeline
  logic [CNT_W-1:0] cnt_q;
  logic             pv_q;
  logic [IDX_W-1:0] pidx_q;

  // Found slot
  logic             found_q;
  logic [IDX_W-1:0] slot_q;
  slot_t            ent_q;

  // Best ready candidate
  logic             best_v_q;
  logic [IDX_W-1:0] best_idx_q;
  logic [15:0]      best_per_q;
  logic [21:0]      best_pid_q;

  // Running task
  logic             run_v_q;
  logic [IDX_W-1:0] run_slot_q;
  logic [15:0]      run_per_q;
  logic [21:0]      run_pid_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic             issue, last, hit, rdy, wake_now, late, admit_ok, free_v, take;
  logic [IDX_W-1:0] free_idx;
  logic [31:0]      adj;

  rmts_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Lowest free slot
  always_comb begin
    free_v   = 1'b0;
    free_idx = '0;
    for (int i = TASKS - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_v   = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  // Scan and datapath helpers
  always_comb begin
    issue    = (cnt_q < CNT_W'(TASKS));
    rd_addr  = cnt_q[IDX_W-1:0];
    last     = pv_q && (pidx_q == IDX_W'(TASKS - 1));
    hit      = pv_q && used_q[pidx_q] && (rd_q.pid == pid_q);
    wake_now = (func_q == FUNC_TICK) && (mode_q[pidx_q] == MODE_SLEEPING)
               && (rd_q.wake <= now_q);
    rdy      = pv_q && used_q[pidx_q] && ((mode_q[pidx_q] == MODE_READY) || wake_now);
    late     = (now_q >= ent_q.deadline);
    admit_ok = free_v && (({17'd0, sum_q} + {1'b0, div_rsp.quot}) <= {17'd0, thr_q});
    adj      = (div_rsp.rem == 16'd0) ? 32'd0 : {16'd0, ent_q.period - div_rsp.rem};
    take     = best_v_q && !(run_v_q && (run_per_q <= best_per_q));
  end

  // Sequencer: next state, divider start and table writes
  always_comb begin
    state_d          = state_q;
    div_req.start    = 1'b0;
    div_req.dividend = prod_q;
    div_req.divisor  = period_q;
    mem_we           = 1'b0;
    mem_wa           = slot_q;
    mem_wd           = ent_q;
    if (func_q == FUNC_YIELD) begin
      div_req.dividend = {{(DIV_W - 32){1'b0}}, now_q - ent_q.deadline};
      div_req.divisor  = ent_q.period;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (func_e'(func_i))
            FUNC_REG:   state_d = (period_ms_i == 16'd0) ? S_DISP : S_MUL;
            FUNC_TICK:  state_d = S_DISP;
            default:    state_d = S_FIND;
          endcase
        end
      end
      S_MUL:  state_d = S_DIVS;
      S_DIVS: begin
        div_req.start = 1'b1;
        state_d       = S_DIVW;
      end
      S_DIVW: begin
        if (div_rsp.done) begin
          state_d = (func_q == FUNC_REG) ? S_ADMIT : S_YFIN;
        end
      end
      S_ADMIT: begin
        mem_wa          = free_idx;
        mem_wd.pid      = pid_q;
        mem_wd.period   = period_q;
        mem_wd.usage    = div_rsp.quot[19:0];
        mem_wd.deadline = now_q + {16'd0, period_q};
        mem_wd.wake     = '0;
        mem_we          = admit_ok;
        state_d         = S_DISP;
      end
      S_FIND: begin
        if (hit || last) begin
          state_d = S_ACT;
        end
      end
      S_ACT: begin
        state_d = S_DISP;
        if (found_q && (func_q == FUNC_YIELD)) begin
          if (late) begin
            div_req.start = 1'b1;
            state_d       = S_DIVW;
          end else begin
            mem_wd.wake     = ent_q.deadline;
            mem_wd.deadline = ent_q.deadline + {16'd0, ent_q.period};
            mem_we          = 1'b1;
          end
        end
      end
      S_YFIN: begin
        mem_wd.deadline = now_q + adj;
        mem_we          = 1'b1;
        state_d         = S_DISP;
      end
      S_DISP: begin
        if (last) begin
          state_d = S_DFIN;
        end
      end
      S_DFIN: state_d = S_OUT;
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Write and read the table memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[rd_addr];
  end

  // Latch the request word and the product
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      func_q    <= func_e'(func_i);
      pid_q     <= pid_i;
      period_q  <= period_ms_i;
      runtime_q <= runtime_ms_i;
      now_q     <= now_i;
    end
    if (state_q == S_MUL) begin
      prod_q <= {20'd0, runtime_q} * {16'd0, MILLIONTHS};
    end
  end

  // Control state, flags and scan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= THRESH_RESET;
      sum_q      <= '0;
      status_q   <= ST_OK;
      cnt_q      <= '0;
      pv_q       <= 1'b0;
      pidx_q     <= '0;
      found_q    <= 1'b0;
      slot_q     <= '0;
      best_v_q   <= 1'b0;
      best_idx_q <= '0;
      best_per_q <= '0;
      best_pid_q <= '0;
      run_v_q    <= 1'b0;
      run_slot_q <= '0;
      run_per_q  <= '0;
      run_pid_q  <= '0;
      for (int i = 0; i < TASKS; i++) begin
        used_q[i] <= 1'b0;
        mode_q[i] <= MODE_READY;
      end
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_data_i;
      end

      // Advance the scan in scan states, rewind it elsewhere
      if (state_q == S_FIND || state_q == S_DISP) begin
        cnt_q  <= issue ? cnt_q + 1'b1 : cnt_q;
        pv_q   <= issue;
        pidx_q <= rd_addr;
      end else begin
        cnt_q    <= '0;
        pv_q     <= 1'b0;
        best_v_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          status_q <= ST_OK;
          found_q  <= 1'b0;
          if (in_valid_i && func_e'(func_i) == FUNC_REG && period_ms_i == 16'd0) begin
            status_q <= ST_ZERO_PERIOD;
          end
        end
        S_ADMIT: begin
          if (admit_ok) begin
            used_q[free_idx] <= 1'b1;
            mode_q[free_idx] <= MODE_RUNNING;
            sum_q            <= sum_q + div_rsp.quot[19:0];
          end else begin
            status_q <= ST_REJECT;
          end
        end
        S_FIND: begin
          if (hit) begin
            found_q <= 1'b1;
            slot_q  <= pidx_q;
          end
        end
        S_ACT: begin
          if (!found_q) begin
            status_q <= ST_NOT_FOUND;
          end else begin
            if (run_v_q && run_slot_q == slot_q) begin
              run_v_q <= 1'b0;
            end
            if (func_q == FUNC_DEREG) begin
              used_q[slot_q] <= 1'b0;
              sum_q          <= sum_q - ent_q.usage;
            end else if (!late) begin
              mode_q[slot_q] <= MODE_SLEEPING;
            end
          end
        end
        S_YFIN: mode_q[slot_q] <= MODE_READY;
        S_DISP: begin
          // Wake due sleepers and keep the lowest-period ready slot
          if (rdy && wake_now) begin
            mode_q[pidx_q] <= MODE_READY;
          end
          if (rdy && (!best_v_q || rd_q.period < best_per_q)) begin
            best_v_q   <= 1'b1;
            best_idx_q <= pidx_q;
            best_per_q <= rd_q.period;
            best_pid_q <= rd_q.pid;
          end
        end
        S_DFIN: begin
          if (take) begin
            if (run_v_q) begin
              mode_q[run_slot_q] <= MODE_READY;
            end
            mode_q[best_idx_q] <= MODE_RUNNING;
            run_v_q            <= 1'b1;
            run_slot_q         <= best_idx_q;
            run_per_q          <= best_per_q;
            run_pid_q          <= best_pid_q;
          end
        end
        default: ;
      endcase
    end
  end

  // Capture the matching entry during the lookup
  always_ff @(posedge clk_i) begin
    if (state_q == S_FIND && hit) begin
      ent_q <= rd_q;
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = (state_q == S_OUT);
  assign status_o      = status_q;
  assign run_valid_o   = run_v_q;
  assign run_pid_o     = run_v_q ? run_pid_q : 22'd0;
  assign total_usage_o = sum_q;

endmodule

### tb/rate_monotonic_task_scheduler_tb.sv
// Testbench for the rate monotonic task scheduler: predicts each result word and checks it.
`timescale 1ns / 100ps

module rate_monotonic_task_scheduler_tb;
  import rmts_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1500000;
  localparam int unsigned HOLD_CYCLES = 3000;

  typedef struct packed {
    func_e       func;
    logic [21:0] pid;
    logic [15:0] period;
    logic [15:0] runtime;
    logic [31:0] now;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic        run_valid;
    logic [21:0] run_pid;
    logic [19:0] total_usage;
  } rsp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  func_i = '0;
  logic [21:0] pid_i = '0;
  logic [15:0] period_ms_i = '0;
  logic [15:0] runtime_ms_i = '0;
  logic [31:0] now_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic        run_valid_o;
  logic [21:0] run_pid_o;
  logic [19:0] total_usage_o;
  logic        cfg_we_i = 1'b0;
  logic [19:0] cfg_data_i = '0;

  rate_monotonic_task_scheduler DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .func_i, .pid_i, .period_ms_i,
    .runtime_ms_i, .now_i, .out_valid_o, .out_stall_i, .status_o, .run_valid_o,
    .run_pid_o, .total_usage_o, .cfg_we_i, .cfg_data_i
  );

  always #10 clk_i = ~clk_i;

  // Scheduler shadow state
  logic        sh_used     [TASKS];
  logic [21:0] sh_pid      [TASKS];
  logic [15:0] sh_period   [TASKS];
  logic [19:0] sh_usage    [TASKS];
  logic [31:0] sh_deadline [TASKS];
  logic [31:0] sh_wake     [TASKS];
  mode_e       sh_mode     [TASKS];
  logic [19:0] sh_sum;
  int          sh_running;
  logic [19:0] sh_thresh;

  req_t  pend_q[$];
  rsp_t  sched_exp_q[$];
  int    err_cnt = 0;
  int    words_in = 0;
  int    words_out = 0;
  int    cycles = 0;
  bit    no_idle = 1'b0;
  bit    hold_req = 1'b0;
  logic [31:0] now_t = 32'd0;

  function automatic int find_slot(logic [21:0] pid);
    for (int i = 0; i < TASKS; i++)
      if (sh_used[i] && sh_pid[i] == pid) return i;
    return -1;
  endfunction

  // Apply one request to the shadow state and queue the expected word
  task automatic predict_sched(req_t r);
    status_e     st;
    int          s;
    int          best;
    logic [63:0] use64;
    logic [63:0] per;
    logic [63:0] k;
    rsp_t        e;
    st = ST_OK;
    case (r.func)
      FUNC_REG: begin
        if (r.period == 0) begin
          st = ST_ZERO_PERIOD;
        end else begin
          use64 = (64'(r.runtime) * 64'd1000000) / 64'(r.period);
          s = -1;
          for (int i = 0; i < TASKS; i++)
            if (!sh_used[i] && s < 0) s = i;
          if (s < 0 || 64'(sh_sum) + use64 > 64'(sh_thresh)) begin
            st = ST_REJECT;
          end else begin
            sh_used[s] = 1'b1;
            sh_pid[s] = r.pid;
            sh_period[s] = r.period;
            sh_usage[s] = use64[19:0];
            sh_deadline[s] = r.now + 32'(r.period);
            sh_wake[s] = '0;
            sh_mode[s] = MODE_RUNNING;
            sh_sum = sh_sum + use64[19:0];
          end
        end
      end
      FUNC_DEREG: begin
        s = find_slot(r.pid);
        if (s < 0) begin
          st = ST_NOT_FOUND;
        end else begin
          if (sh_running == s) sh_running = TASKS;
          sh_used[s] = 1'b0;
          sh_sum = sh_sum - sh_usage[s];
        end
      end
      FUNC_YIELD: begin
        s = find_slot(r.pid);
        if (s < 0) begin
          st = ST_NOT_FOUND;
        end else begin
          if (sh_running == s) sh_running = TASKS;
          per = 64'(sh_period[s]);
          if (r.now >= sh_deadline[s]) begin
            k = (per != 0) ? (64'(r.now - sh_deadline[s]) + per - 1) / per : 0;
            sh_deadline[s] = sh_deadline[s] + 32'(k * per);
            sh_mode[s] = MODE_READY;
          end else begin
            sh_wake[s] = sh_deadline[s];
            sh_deadline[s] = sh_deadline[s] + 32'(per);
            sh_mode[s] = MODE_SLEEPING;
          end
        end
      end
      default: begin
        for (int i = 0; i < TASKS; i++)
          if (sh_used[i] && sh_mode[i] == MODE_SLEEPING && sh_wake[i] <= r.now)
            sh_mode[i] = MODE_READY;
      end
    endcase
    // Dispatch: lowest period ready task, running task wins ties
    best = -1;
    for (int i = 0; i < TASKS; i++)
      if (sh_used[i] && sh_mode[i] == MODE_READY &&
          (best < 0 || sh_period[i] < sh_period[best])) best = i;
    if (best >= 0) begin
      if (sh_running >= TASKS || sh_period[sh_running] > sh_period[best]) begin
        if (sh_running < TASKS) sh_mode[sh_running] = MODE_READY;
        sh_mode[best] = MODE_RUNNING;
        sh_running = best;
      end
    end
    e.status = st;
    e.run_valid = (sh_running < TASKS);
    e.run_pid = (sh_running < TASKS) ? sh_pid[sh_running] : '0;
    e.total_usage = sh_sum;
    sched_exp_q.push_back(e);
  endtask

  // Driver: offer pending words, with random idle gaps between them unless no_idle is set
  int gap_cnt = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_cnt <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_sched(req_t'({func_e'(func_i), pid_i, period_ms_i, runtime_ms_i, now_i}));
        words_in++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_cnt > 0) begin
          gap_cnt <= gap_cnt - 1;
          in_valid_i <= 1'b0;
        end else if (pend_q.size() > 0) begin
          req_t r;
          r = pend_q.pop_front();
          func_i <= r.func;
          pid_i <= r.pid;
          period_ms_i <= r.period;
          runtime_ms_i <= r.runtime;
          now_i <= r.now;
          in_valid_i <= 1'b1;
          gap_cnt <= no_idle ? 0 : $urandom_range(0, 19);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result word, stall at random or for a long hold-off
  int stall_cnt = 0;
  int hold_cnt = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        words_out++;
        if (sched_exp_q.size() == 0) begin
          $error("result word with no expectation waiting");
          err_cnt++;
        end else begin
          rsp_t e;
          e = sched_exp_q.pop_front();
          if (status_o !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, status_o);
            err_cnt++;
          end
          if (run_valid_o !== e.run_valid) begin
            $error("run_valid: expected %0d, got %0d", e.run_valid, run_valid_o);
            err_cnt++;
          end
          if (run_pid_o !== e.run_pid) begin
            $error("run_pid: expected %0h, got %0h", e.run_pid, run_pid_o);
            err_cnt++;
          end
          if (total_usage_o !== e.total_usage) begin
            $error("total_usage: expected %0d, got %0d", e.total_usage, total_usage_o);
            err_cnt++;
          end
        end
        stall_cnt = no_idle ? 0 : $urandom_range(0, 19);
      end
      if (hold_req && hold_cnt == 0) begin
        hold_cnt = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall_i <= 1'b1;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic req_t mk(func_e f, logic [21:0] pid, logic [15:0] per,
                              logic [15:0] rt);
    req_t r;
    r.func = f;
    r.pid = pid;
    r.period = per;
    r.runtime = rt;
    r.now = now_t;
    return r;
  endfunction

  // Random request: mostly a small pid pool with light tasks, some noise
  function automatic req_t rand_req();
    int          sel;
    logic [21:0] pid;
    logic [15:0] per;
    logic [15:0] rt;
    if (now_t < 32'hFFFF_F000) now_t = now_t + $urandom_range(0, 30);
    pid = ($urandom_range(0, 9) == 0) ? 22'($urandom) : 22'($urandom_range(1, 12));
    sel = $urandom_range(0, 99);
    if (sel < 10) begin
      per = 16'($urandom);
      rt = 16'($urandom);
    end else begin
      per = 16'($urandom_range(1, 120));
      rt = 16'($urandom_range(0, 32'(per) / 10));
    end
    sel = $urandom_range(0, 99);
    if (sel < 28) return mk(FUNC_REG, pid, per, rt);
    if (sel < 40) return mk(FUNC_DEREG, pid, per, rt);
    if (sel < 75) return mk(FUNC_YIELD, pid, 16'($urandom), 16'($urandom));
    return mk(FUNC_TICK, 22'($urandom), 16'($urandom), 16'($urandom));
  endfunction

  task automatic wait_idle();
    while (pend_q.size() > 0 || in_valid_i || sched_exp_q.size() > 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_thresh(logic [19:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sh_thresh = v;
  endtask

  task automatic random_phase(logic [19:0] thr, int n, bit quiet);
    wait_idle();
    write_thresh(thr);
    no_idle = quiet;
    for (int i = 0; i < n; i++) pend_q.push_back(rand_req());
    wait_idle();
    no_idle = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < TASKS; i++) begin
      sh_used[i] = 1'b0;
      sh_pid[i] = '0;
      sh_period[i] = '0;
      sh_usage[i] = '0;
      sh_deadline[i] = '0;
      sh_wake[i] = '0;
      sh_mode[i] = MODE_READY;
    end
    sh_sum = '0;
    sh_running = TASKS;
    sh_thresh = THRESH_RESET;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: zero period, over threshold, new tasks, duplicates, unknown pids
    write_thresh(THRESH_RESET);
    now_t = 32'd100;
    pend_q.push_back(mk(FUNC_REG, 22'd0, 16'd0, 16'd5));
    pend_q.push_back(mk(FUNC_REG, 22'h3FFFFF, 16'hFFFF, 16'hFFFF));
    pend_q.push_back(mk(FUNC_REG, 22'h3FFFFF, 16'd10, 16'd1));
    pend_q.push_back(mk(FUNC_REG, 22'd5, 16'd20, 16'd2));
    pend_q.push_back(mk(FUNC_REG, 22'd5, 16'd10, 16'd1));
    pend_q.push_back(mk(FUNC_DEREG, 22'd77, 16'd0, 16'd0));
    pend_q.push_back(mk(FUNC_YIELD, 22'd77, 16'd0, 16'd0));
    // Yield before deadline sleeps; tick wakes; equal periods tie
    pend_q.push_back(mk(FUNC_YIELD, 22'h3FFFFF, 16'd0, 16'd0));
    pend_q.push_back(mk(FUNC_YIELD, 22'd5, 16'd0, 16'd0));
    now_t = 32'd112;
    pend_q.push_back(mk(FUNC_TICK, 22'h3FFFFF, 16'hFFFF, 16'hFFFF));
    now_t = 32'd125;
    pend_q.push_back(mk(FUNC_TICK, 22'd0, 16'd0, 16'd0));
    // Overshot deadline: ready at once
    now_t = 32'd400;
    pend_q.push_back(mk(FUNC_YIELD, 22'd5, 16'd0, 16'd0));
    pend_q.push_back(mk(FUNC_YIELD, 22'h3FFFFF, 16'd0, 16'd0));
    pend_q.push_back(mk(FUNC_DEREG, 22'd5, 16'd0, 16'd0));
    // Register ten more zero-usage tasks; the table does not fill
    for (int i = 0; i < 10; i++)
      pend_q.push_back(mk(FUNC_REG, 22'(100 + i), 16'(i + 1), 16'd0));
    wait_idle();

    // Random phases over several thresholds, extremes included
    random_phase(20'd1000000, 300, 1'b0);
    random_phase(20'd0, 150, 1'b1);
    random_phase(20'($urandom_range(0, 1000000)), 300, 1'b0);

    // Back-pressure: receiver holds off while the sender keeps offering
    wait_idle();
    hold_req = 1'b1;
    no_idle = 1'b1;
    for (int i = 0; i < 100; i++) pend_q.push_back(rand_req());
    wait_idle();
    no_idle = 1'b0;

    random_phase(20'd200000, 300, 1'b0);
    // Late time base so the upper bits of now toggle, deadlines may wrap
    now_t = 32'hFFFF_0000;
    random_phase(THRESH_RESET, 300, 1'b0);
    random_phase(20'hFFFFF, 150, 1'b0);
    random_phase(20'd1000000, 300, 1'b1);

    wait_idle();
    $display("Sent %0d request words, checked %0d result words over six thresholds,",
             words_in, words_out);
    $display("with random idling, one long receiver hold-off and a late time base.");
    if (err_cnt == 0 && sched_exp_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
